>>> hdl/vsv_pkg.sv
// shared types and constants for the vector segment validator
package vsv_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        channel_kind;
        logic [31:0] vector_dimension;
        logic [10:0] record_total;
        logic [63:0] payload_start;
    } out_item_t;

    typedef struct packed {
        logic [15:0] format_version;
        logic [31:0] max_dimension;
        logic [10:0] max_records;
        logic [7:0]  visual_channel_code;
        logic [7:0]  text_channel_code;
    } cfg_t;

    // item tagged by the front end with its file offset and class
    typedef struct packed {
        logic [63:0] pos;
        logic        is_hdr;
        logic [7:0]  data_byte;
        logic        last_byte;
    } q_entry_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int HEADER_BYTES = 128;
    localparam int ENTRY_BYTES = 24;

    localparam logic [2:0] REG_FORMAT_VERSION = 3'd0;
    localparam logic [2:0] REG_MAX_DIMENSION  = 3'd1;
    localparam logic [2:0] REG_MAX_RECORDS    = 3'd2;
    localparam logic [2:0] REG_VISUAL_CODE    = 3'd3;
    localparam logic [2:0] REG_TEXT_CODE      = 3'd4;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_TRUNCATED = 4'd1;
    localparam logic [3:0] ST_MAGIC     = 4'd2;
    localparam logic [3:0] ST_VERSION   = 4'd3;
    localparam logic [3:0] ST_HEADER    = 4'd4;
    localparam logic [3:0] ST_CHANNEL   = 4'd5;
    localparam logic [3:0] ST_ENCODING  = 4'd6;
    localparam logic [3:0] ST_SHAPE     = 4'd7;
    localparam logic [3:0] ST_IDENTITY  = 4'd8;
    localparam logic [3:0] ST_LAYOUT    = 4'd9;
    localparam logic [3:0] ST_RECORD    = 4'd10;
    localparam logic [3:0] ST_DUPLICATE = 4'd11;
    localparam logic [3:0] ST_PADDING   = 4'd12;

    // "NAYTIVEC" read little-endian
    localparam logic [63:0] MAGIC_WORD = 64'h434556495459414E;

endpackage

>>> hdl/vsv_front.sv
// front end: accepts bytes, tracks file offset, tags header bytes
module vsv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vsv_pkg::in_item_t   in_data,
    input  logic                q_full,
    output logic                q_push,
    output vsv_pkg::q_entry_t   q_data
);

    logic [63:0] pos_reg;
    logic [63:0] pos_next;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_data.pos       = pos_reg;
        q_data.is_hdr    = (pos_reg < 64'(vsv_pkg::HEADER_BYTES));
        q_data.data_byte = in_data.data_byte;
        q_data.last_byte = in_data.last_byte;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            if (in_data.last_byte)
                pos_next = '0;
            else if (!(&pos_reg))
                pos_next = pos_reg + 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

>>> hdl/vsv_queue.sv
// short queue between the front end and the checker
module vsv_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vsv_pkg::q_entry_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              avail,
    output vsv_pkg::q_entry_t pop_data
);

    localparam int PW = $clog2(vsv_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(vsv_pkg::QUEUE_DEPTH + 1);

    vsv_pkg::q_entry_t mem_reg [vsv_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] rd_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    assign full     = (cnt_reg == CW'(vsv_pkg::QUEUE_DEPTH));
    assign avail    = (cnt_reg != '0);
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(pop && avail))
            cnt_next = cnt_reg + 1'b1;
        else if (!push && pop && avail)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop && avail)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hdl/vsv_back.sv
// checker: header decode, record checks with duplicate scan, result register
module vsv_back #(
    parameter int RECORD_CAPACITY = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vsv_pkg::cfg_t      cfg,
    input  logic               q_avail,
    input  vsv_pkg::q_entry_t  q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output vsv_pkg::out_item_t out_data
);

    localparam int AW    = (RECORD_CAPACITY > 1) ? $clog2(RECORD_CAPACITY) : 1;
    localparam int CNT_W = $clog2(RECORD_CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DEC_A    = 8'b0000_0010,
        S_DEC_B    = 8'b0000_0100,
        S_REC_CHK  = 8'b0000_1000,
        S_SCAN_RD  = 8'b0001_0000,
        S_SCAN_CMP = 8'b0010_0000,
        S_STORE    = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic [63:0] rid;
        logic [63:0] aid;
        logic [31:0] ord;
    } rec_t;

    state_t state_reg;
    state_t state_next;

    logic [127:0][7:0] hdr_reg;
    logic [23:0][7:0]  ent_reg;
    logic [4:0]        fill_reg;
    logic [CNT_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic [3:0]        pend_reg;
    logic [3:0]        rec_err_reg;
    logic              pad_err_reg;
    logic              hready_reg;
    logic              kind_reg;
    logic [15:0]       tab_end_reg;
    logic [42:0]       prod_reg;
    logic              last_reg;
    logic [63:0]       pos_reg;
    logic [3:0]        err_a_reg;
    rec_t              rd_reg;
    rec_t              rec_mem [RECORD_CAPACITY];
    logic              out_valid_reg;
    vsv_pkg::out_item_t out_reg;

    // header fields
    logic [31:0] h_dim;
    logic [31:0] h_cnt;
    logic [63:0] h_tab;
    logic [63:0] h_off;
    logic [63:0] h_plen;
    logic [63:0] h_flen;
    logic [7:0]  h_ch;
    logic [16:0] limit;
    logic [3:0]  err_a;
    logic        kind_a;
    logic        lay_bad;

    // record fields
    rec_t        cur;
    logic [31:0] flg;
    logic        rec_bad;
    logic        dup_hit;

    // item handling
    logic        take;
    logic        in_table;
    logic        rec_done;
    logic        can_emit;
    logic [63:0] pos_after;
    logic [3:0]  status;
    state_t      after_rec;

    assign h_dim  = hdr_reg[16 +: 4];
    assign h_cnt  = hdr_reg[20 +: 4];
    assign h_tab  = hdr_reg[28 +: 8];
    assign h_off  = hdr_reg[36 +: 8];
    assign h_plen = hdr_reg[44 +: 8];
    assign h_flen = hdr_reg[52 +: 8];
    assign h_ch   = hdr_reg[12];

    assign limit = (17'(cfg.max_records) > 17'(RECORD_CAPACITY)) ?
                   17'(RECORD_CAPACITY) : 17'(cfg.max_records);

    always_comb
    begin
        kind_a = 1'b0;
        if (hdr_reg[0 +: 8] != vsv_pkg::MAGIC_WORD)
            err_a = vsv_pkg::ST_MAGIC;
        else if (hdr_reg[8 +: 2] != cfg.format_version)
            err_a = vsv_pkg::ST_VERSION;
        else if (hdr_reg[10 +: 2] != 16'(vsv_pkg::HEADER_BYTES) ||
                 hdr_reg[24 +: 2] != 16'(vsv_pkg::ENTRY_BYTES) ||
                 hdr_reg[26 +: 2] != 16'd0 || (|hdr_reg[108 +: 20]) ||
                 hdr_reg[15] != 8'd0)
            err_a = vsv_pkg::ST_HEADER;
        else if (h_ch != cfg.visual_channel_code && h_ch != cfg.text_channel_code)
            err_a = vsv_pkg::ST_CHANNEL;
        else if (hdr_reg[13] != 8'd1 || hdr_reg[14] != 8'd1)
            err_a = vsv_pkg::ST_ENCODING;
        else if (h_dim == 32'd0 || h_dim > cfg.max_dimension || h_cnt == 32'd0 ||
                 h_cnt > 32'(limit))
            err_a = vsv_pkg::ST_SHAPE;
        else if (!(|hdr_reg[60 +: 32]) || !(|hdr_reg[92 +: 16]))
            err_a = vsv_pkg::ST_IDENTITY;
        else
            err_a = vsv_pkg::ST_OK;
        if (h_ch != cfg.visual_channel_code)
            kind_a = 1'b1;
    end

    assign lay_bad = h_tab != 64'(vsv_pkg::HEADER_BYTES) ||
                     h_off < 64'(tab_end_reg) || h_off[5:0] != 6'd0 ||
                     h_plen != 64'(prod_reg) || h_off > h_flen ||
                     h_plen != h_flen - h_off;

    assign cur.rid = ent_reg[0 +: 8];
    assign cur.aid = ent_reg[8 +: 8];
    assign cur.ord = ent_reg[16 +: 4];
    assign flg     = ent_reg[20 +: 4];

    assign rec_bad = cur.rid == 64'd0 || cur.aid == 64'd0 || flg != 32'd0 ||
                     (!kind_reg && (cur.rid != cur.aid || cur.ord != 32'd0));
    assign dup_hit = rd_reg.rid == cur.rid ||
                     (kind_reg && rd_reg.aid == cur.aid && rd_reg.ord == cur.ord);

    assign take     = (state_reg == S_IDLE) && q_avail;
    assign q_pop    = take;
    assign in_table = q_data.pos < 64'(tab_end_reg);
    assign rec_done = !q_data.is_hdr && hready_reg && pend_reg == vsv_pkg::ST_OK &&
                      in_table && fill_reg == 5'(vsv_pkg::ENTRY_BYTES - 1);
    assign can_emit  = !out_valid_reg || out_ready;
    assign pos_after = (&pos_reg) ? pos_reg : pos_reg + 64'd1;
    assign after_rec = last_reg ? S_EMIT : S_IDLE;

    always_comb
    begin
        if (!hready_reg)
            status = vsv_pkg::ST_TRUNCATED;
        else if (pend_reg != vsv_pkg::ST_OK)
            status = pend_reg;
        else if (h_flen != pos_after)
            status = vsv_pkg::ST_LAYOUT;
        else if (pad_err_reg)
            status = vsv_pkg::ST_PADDING;
        else
            status = rec_err_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (q_data.is_hdr && q_data.pos[6:0] == 7'(vsv_pkg::HEADER_BYTES - 1))
                        state_next = S_DEC_A;
                    else if (rec_done && rec_err_reg == vsv_pkg::ST_OK)
                        state_next = S_REC_CHK;
                    else if (q_data.last_byte)
                        state_next = S_EMIT;
                end
            end
            S_DEC_A:
                state_next = S_DEC_B;
            S_DEC_B:
                state_next = after_rec;
            S_REC_CHK:
            begin
                if (rec_bad)
                    state_next = after_rec;
                else if (acc_reg == '0)
                    state_next = S_STORE;
                else
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
                state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if (dup_hit)
                    state_next = after_rec;
                else if (scan_reg + 1'b1 == acc_reg)
                    state_next = S_STORE;
                else
                    state_next = S_SCAN_RD;
            end
            S_STORE:
                state_next = after_rec;
            S_EMIT:
            begin
                if (can_emit)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // record store, registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STORE && acc_reg < CNT_W'(RECORD_CAPACITY))
            rec_mem[acc_reg[AW-1:0]] <= cur;
        rd_reg <= rec_mem[scan_reg[AW-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pos_reg  <= q_data.pos;
            last_reg <= q_data.last_byte;
            if (q_data.is_hdr)
                hdr_reg[q_data.pos[6:0]] <= q_data.data_byte;
            else if (hready_reg && pend_reg == vsv_pkg::ST_OK && in_table)
                ent_reg[fill_reg] <= q_data.data_byte;
        end
        if (state_reg == S_DEC_A)
        begin
            err_a_reg   <= err_a;
            kind_reg    <= kind_a;
            tab_end_reg <= 16'(vsv_pkg::HEADER_BYTES) + 16'(h_cnt[10:0]) *
                           16'(vsv_pkg::ENTRY_BYTES);
            prod_reg    <= 43'(h_cnt[10:0]) * 43'(h_dim);
        end
        if (state_reg == S_EMIT && can_emit)
        begin
            out_reg.status <= status;
            if (status == vsv_pkg::ST_OK)
            begin
                out_reg.channel_kind     <= kind_reg;
                out_reg.vector_dimension <= h_dim;
                out_reg.record_total     <= h_cnt[10:0];
                out_reg.payload_start    <= h_off;
            end
            else
            begin
                out_reg.channel_kind     <= 1'b0;
                out_reg.vector_dimension <= '0;
                out_reg.record_total     <= '0;
                out_reg.payload_start    <= '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            acc_reg       <= '0;
            scan_reg      <= '0;
            pend_reg      <= vsv_pkg::ST_OK;
            rec_err_reg   <= vsv_pkg::ST_OK;
            pad_err_reg   <= 1'b0;
            hready_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (take && !q_data.is_hdr && hready_reg &&
                        pend_reg == vsv_pkg::ST_OK)
                    begin
                        if (in_table)
                            fill_reg <= rec_done ? 5'd0 : fill_reg + 5'd1;
                        else if (q_data.pos < h_off && q_data.data_byte != 8'd0)
                            pad_err_reg <= 1'b1;
                    end
                end
                S_DEC_B:
                begin
                    hready_reg <= 1'b1;
                    if (err_a_reg != vsv_pkg::ST_OK)
                        pend_reg <= err_a_reg;
                    else if (lay_bad)
                        pend_reg <= vsv_pkg::ST_LAYOUT;
                end
                S_REC_CHK:
                begin
                    scan_reg <= '0;
                    if (rec_bad)
                        rec_err_reg <= vsv_pkg::ST_RECORD;
                end
                S_SCAN_CMP:
                begin
                    if (dup_hit)
                        rec_err_reg <= vsv_pkg::ST_DUPLICATE;
                    else
                        scan_reg <= scan_reg + 1'b1;
                end
                S_STORE:
                begin
                    if (acc_reg < CNT_W'(RECORD_CAPACITY))
                        acc_reg <= acc_reg + 1'b1;
                end
                S_EMIT:
                begin
                    if (can_emit)
                    begin
                        out_valid_reg <= 1'b1;
                        fill_reg      <= '0;
                        acc_reg       <= '0;
                        pend_reg      <= vsv_pkg::ST_OK;
                        rec_err_reg   <= vsv_pkg::ST_OK;
                        pad_err_reg   <= 1'b0;
                        hready_reg    <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> hdl/vector_segment_validator.sv
// top level of the vector segment validator
//
// one segment file arrives as a stream of items on in_valid/in_ready, one
// byte per item, last_byte set on the final byte. exactly one result item
// leaves on out_valid/out_ready per file: a status code and, when the
// status is ok, the channel kind, dimension, record count and payload offset.
// a front end tags each byte with its file offset and places it in a
// four-entry queue; the checker drains the queue one byte per cycle while
// idle, and takes no bytes while it decodes the header after its last
// byte, while it checks a record against the records already stored in
// the record memory, or while a result waits. the result is held in an
// output register; while the receiver stalls, the queue keeps taking bytes
// of the next file until it is full. reset clears the offset, counters and
// error state; the record memory needs no clearing, since only entries
// written for the current file are read. the user must write configuration
// through cfg_we/cfg_index/cfg_data only while idle; the block itself does
// not enforce this.
module vector_segment_validator #(
    parameter int RECORD_CAPACITY = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vsv_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output vsv_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    vsv_pkg::cfg_t     cfg_reg;
    logic              q_full;
    logic              q_push;
    vsv_pkg::q_entry_t q_in;
    logic              q_pop;
    logic              q_avail;
    vsv_pkg::q_entry_t q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.format_version      <= 16'd1;
            cfg_reg.max_dimension       <= 32'd4096;
            cfg_reg.max_records         <= 11'd1024;
            cfg_reg.visual_channel_code <= 8'd1;
            cfg_reg.text_channel_code   <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vsv_pkg::REG_FORMAT_VERSION: cfg_reg.format_version <= cfg_data[15:0];
                vsv_pkg::REG_MAX_DIMENSION:  cfg_reg.max_dimension <= cfg_data;
                vsv_pkg::REG_MAX_RECORDS:    cfg_reg.max_records <= cfg_data[10:0];
                vsv_pkg::REG_VISUAL_CODE:    cfg_reg.visual_channel_code <= cfg_data[7:0];
                vsv_pkg::REG_TEXT_CODE:      cfg_reg.text_channel_code <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    vsv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    vsv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .pop_data  (q_out)
    );

    vsv_back #(
        .RECORD_CAPACITY (RECORD_CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_avail   (q_avail),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= vsv_pkg::ST_PADDING)
        else $error("status code out of range");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != vsv_pkg::ST_OK |->
            out_data.record_total == '0 && out_data.vector_dimension == '0 &&
            out_data.payload_start == '0 && !out_data.channel_kind)
        else $error("fields not cleared on failing status");

    a_ok_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == vsv_pkg::ST_OK |->
            out_data.record_total != '0 && out_data.vector_dimension != '0 &&
            out_data.payload_start[5:0] == 6'd0)
        else $error("ok result with bad shape or alignment");

endmodule

>>> dv/tb_vector_segment_validator.sv
// testbench for the vector segment validator: segment files, predictor and result checks
module tb_vector_segment_validator;
    import vsv_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int NO_TYPED = -1;

    typedef enum int {
        C_NONE, C_TRUNC, C_NOISE, C_MAGIC, C_VERSION, C_HDRLEN, C_CHANNEL, C_ENCODING,
        C_SHAPE_DIM, C_SHAPE_CNT, C_IDENT, C_LAYOUT_TAB, C_FILELEN, C_PADDING,
        C_RECZERO, C_FLAGS, C_VISMISMATCH, C_DUP
    } flaw_e;

    typedef struct {
        flaw_e c;
        int    kind;
        int    n;
        int    dim;
        int    typed;
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    vector_segment_validator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // configuration copy
    logic [15:0] cfg_ver;
    logic [31:0] cfg_dim;
    logic [10:0] cfg_rec;
    logic [7:0]  cfg_vis;
    logic [7:0]  cfg_txt;

    // segment predictor state
    logic [7:0]  pv_hdr [128];
    logic [7:0]  pv_ent [24];
    int          pv_fill;
    logic [63:0] pv_rid [1024];
    logic [63:0] pv_aid [1024];
    logic [31:0] pv_ord [1024];
    int          pv_stored;
    logic [3:0]  pv_hdr_err;
    logic [3:0]  pv_rec_err;
    logic [3:0]  pv_pad_err;
    bit          pv_hdr_done;
    logic        pv_kind;
    logic [31:0] pv_dim;
    logic [10:0] pv_cnt;
    logic [63:0] pv_tab_end;
    logic [63:0] pv_off;
    logic [63:0] pv_flen;
    logic [63:0] pv_pos;

    out_item_t   verdicts_due [$];
    int          typed_status_q [$];
    logic [7:0]  seg_bytes [$];
    logic [7:0]  img_hdr [128];

    int  fails;
    int  cycles;
    int  bytes_sent;
    int  files_sent;
    int  verdicts_seen;
    bit  tx_idle;
    bit  rx_idle;
    bit  rx_long;

    function automatic logic [63:0] hdr_le(int off, int n);
        logic [63:0] v;
        v = 0;
        for (int i = 0; i < n; i++)
            v |= 64'(pv_hdr[off + i]) << (8 * i);
        return v;
    endfunction

    function automatic logic [63:0] ent_le(int off, int n);
        logic [63:0] v;
        v = 0;
        for (int i = 0; i < n; i++)
            v |= 64'(pv_ent[off + i]) << (8 * i);
        return v;
    endfunction

    function automatic bit hdr_zero(int off, int n);
        for (int i = 0; i < n; i++)
            if (pv_hdr[off + i] != 0)
                return 0;
        return 1;
    endfunction

    task automatic start_segment();
        pv_fill = 0;
        pv_stored = 0;
        pv_hdr_err = ST_OK;
        pv_rec_err = ST_OK;
        pv_pad_err = ST_OK;
        pv_hdr_done = 0;
        pv_kind = 0;
        pv_dim = 0;
        pv_cnt = 0;
        pv_tab_end = 0;
        pv_off = 0;
        pv_flen = 0;
        pv_pos = 0;
    endtask

    task automatic decode_header(output logic [3:0] st);
        logic [63:0] limit;
        logic [63:0] cnt;
        logic [63:0] tab;
        logic [63:0] plen;
        limit = (cfg_rec > 11'd1024) ? 64'd1024 : 64'(cfg_rec);
        st = ST_OK;
        if (hdr_le(0, 8) != MAGIC_WORD)
            st = ST_MAGIC;
        else if (hdr_le(8, 2) != 64'(cfg_ver))
            st = ST_VERSION;
        else if (hdr_le(10, 2) != 128 || hdr_le(24, 2) != 24 || hdr_le(26, 2) != 0 ||
                 !hdr_zero(108, 20) || pv_hdr[15] != 0)
            st = ST_HEADER;
        else if (pv_hdr[12] != cfg_vis && pv_hdr[12] != cfg_txt)
            st = ST_CHANNEL;
        else if (pv_hdr[13] != 1 || pv_hdr[14] != 1)
            st = ST_ENCODING;
        else
        begin
            // equal codes resolve to visual
            pv_kind = (pv_hdr[12] == cfg_vis) ? 1'b0 : 1'b1;
            pv_dim = hdr_le(16, 4);
            cnt = hdr_le(20, 4);
            if (pv_dim == 0 || pv_dim > cfg_dim || cnt == 0 || cnt > limit)
                st = ST_SHAPE;
            else
            begin
                pv_cnt = cnt[10:0];
                if (hdr_zero(60, 32) || hdr_zero(92, 16))
                    st = ST_IDENTITY;
                else
                begin
                    tab = hdr_le(28, 8);
                    pv_off = hdr_le(36, 8);
                    plen = hdr_le(44, 8);
                    pv_flen = hdr_le(52, 8);
                    pv_tab_end = 128 + cnt * 24;
                    if (tab != 128 || pv_off < pv_tab_end || pv_off[5:0] != 0 ||
                        plen != cnt * 64'(pv_dim) || pv_off > pv_flen ||
                        plen != pv_flen - pv_off)
                        st = ST_LAYOUT;
                end
            end
        end
    endtask

    task automatic check_entry();
        logic [63:0] rid;
        logic [63:0] aid;
        logic [31:0] ord;
        logic [31:0] flg;
        rid = ent_le(0, 8);
        aid = ent_le(8, 8);
        ord = ent_le(16, 4);
        flg = ent_le(20, 4);
        if (rid == 0 || aid == 0 || flg != 0 || (pv_kind == 0 && (rid != aid || ord != 0)))
        begin
            pv_rec_err = ST_RECORD;
            return;
        end
        for (int i = 0; i < pv_stored; i++)
            if (pv_rid[i] == rid || (pv_kind == 1 && pv_aid[i] == aid && pv_ord[i] == ord))
            begin
                pv_rec_err = ST_DUPLICATE;
                return;
            end
        if (pv_stored < 1024)
        begin
            pv_rid[pv_stored] = rid;
            pv_aid[pv_stored] = aid;
            pv_ord[pv_stored] = ord;
            pv_stored++;
        end
    endtask

    task automatic predict_byte(in_item_t it);
        logic [63:0] p;
        logic [3:0]  st;
        out_item_t   r;
        int          typed;
        p = pv_pos;
        if (pv_pos != '1)
            pv_pos++;
        if (p < 128)
        begin
            pv_hdr[p] = it.data_byte;
            if (p == 127)
            begin
                decode_header(st);
                pv_hdr_err = st;
                pv_hdr_done = 1;
            end
        end
        else if (pv_hdr_done && pv_hdr_err == ST_OK)
        begin
            if (p < pv_tab_end)
            begin
                pv_ent[pv_fill] = it.data_byte;
                pv_fill++;
                if (pv_fill >= 24)
                begin
                    pv_fill = 0;
                    if (pv_rec_err == ST_OK)
                        check_entry();
                end
            end
            else if (p < pv_off)
            begin
                if (it.data_byte != 0 && pv_pad_err == ST_OK)
                    pv_pad_err = ST_PADDING;
            end
        end
        if (!it.last_byte)
            return;
        if (!pv_hdr_done)
            st = ST_TRUNCATED;
        else if (pv_hdr_err != ST_OK)
            st = pv_hdr_err;
        else if (pv_flen != pv_pos)
            st = ST_LAYOUT;
        else if (pv_pad_err != ST_OK)
            st = pv_pad_err;
        else
            st = pv_rec_err;
        r = '0;
        r.status = st;
        if (st == ST_OK)
        begin
            r.channel_kind = pv_kind;
            r.vector_dimension = pv_dim;
            r.record_total = pv_cnt;
            r.payload_start = pv_off;
        end
        typed = (typed_status_q.size() > 0) ? typed_status_q.pop_front() : NO_TYPED;
        if (typed != NO_TYPED)
        begin
            r = '0;
            r.status = 4'(typed);
        end
        verdicts_due.push_back(r);
        start_segment();
    endtask

    function automatic void img_put(int off, logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
            img_hdr[off + i] = v[8 * i +: 8];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void push_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++)
            seg_bytes.push_back(v[8 * i +: 8]);
    endfunction

    task automatic build_segment(flaw_e c, int kind_sel, int n_in, int dim_in);
        int          n;
        int          r;
        int          limit;
        int          kind;
        logic [31:0] dim;
        logic [7:0]  ch;
        logic [63:0] tab_end;
        logic [63:0] off;
        logic [63:0] plen;
        logic [63:0] flen;
        logic [63:0] rid [64];
        logic [63:0] aid [64];
        logic [31:0] ord [64];
        logic [31:0] flg [64];
        logic [63:0] a0;
        logic [63:0] a1;
        seg_bytes.delete();
        if (c == C_TRUNC)
        begin
            repeat ($urandom_range(1, 127)) seg_bytes.push_back(8'($urandom));
            return;
        end
        if (c == C_NOISE)
        begin
            repeat ($urandom_range(128, 160)) seg_bytes.push_back(8'($urandom));
            return;
        end
        limit = (cfg_rec > 11'd1024) ? 1024 : int'(cfg_rec);
        kind = (c == C_VISMISMATCH) ? 0 : kind_sel;
        n = (n_in > limit) ? limit : n_in;
        if (c == C_DUP && n < 2 && limit >= 2)
            n = 2;
        dim = (32'(dim_in) > cfg_dim) ? cfg_dim : 32'(dim_in);
        ch = kind ? cfg_txt : cfg_vis;
        tab_end = 128 + 24 * n;
        off = ((tab_end + 63) / 64) * 64;
        if (c == C_PADDING)
            off += 64;
        plen = 64'(n) * 64'(dim);
        flen = off + plen;

        for (int i = 0; i < 128; i++)
            img_hdr[i] = 0;
        img_put(0, MAGIC_WORD, 8);
        img_put(8, 64'(cfg_ver), 2);
        img_put(10, 128, 2);
        img_hdr[12] = ch;
        img_hdr[13] = 1;
        img_hdr[14] = 1;
        img_put(16, 64'(dim), 4);
        img_put(20, 64'(n), 4);
        img_put(24, 24, 2);
        img_put(28, 128, 8);
        img_put(36, off, 8);
        img_put(44, plen, 8);
        img_put(52, flen, 8);
        // hash and id: random but never all zero
        for (int i = 60; i < 108; i++)
            img_hdr[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
        img_hdr[$urandom_range(60, 91)] = 8'($urandom_range(1, 255));
        img_hdr[$urandom_range(92, 107)] = 8'($urandom_range(1, 255));

        case (c)
            C_MAGIC:    img_hdr[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
            C_VERSION:  img_put(8, 64'(cfg_ver + 16'd1), 2);
            C_HDRLEN:
                case ($urandom_range(0, 4))
                    0: img_put(10, 127, 2);
                    1: img_put(24, 23, 2);
                    2: img_hdr[$urandom_range(26, 27)] = 8'($urandom_range(1, 255));
                    3: img_hdr[$urandom_range(108, 127)] = 8'($urandom_range(1, 255));
                    default: img_hdr[15] = 8'($urandom_range(1, 255));
                endcase
            C_CHANNEL:
            begin
                do ch = 8'($urandom); while (ch == cfg_vis || ch == cfg_txt);
                img_hdr[12] = ch;
            end
            C_ENCODING: img_hdr[$urandom_range(13, 14)] = 8'($urandom_range(2, 255));
            C_SHAPE_DIM: img_put(16, (cfg_dim == '1) ? 64'd0 : 64'(cfg_dim) + 1, 4);
            C_SHAPE_CNT: img_put(20, $urandom_range(0, 1) ? 64'd0 : 64'(limit + 1), 4);
            C_IDENT:
                if ($urandom_range(0, 1))
                    for (int i = 60; i < 92; i++) img_hdr[i] = 0;
                else
                    for (int i = 92; i < 108; i++) img_hdr[i] = 0;
            C_LAYOUT_TAB:
                case ($urandom_range(0, 2))
                    0: img_put(28, 129, 8);
                    1: img_put(36, off + 1, 8);
                    default: img_put(44, plen + 1, 8);
                endcase
            default: ;
        endcase
        for (int i = 0; i < 128; i++)
            seg_bytes.push_back(img_hdr[i]);
        if (c >= C_MAGIC && c <= C_LAYOUT_TAB)
        begin
            // header already fails, a few trailing bytes are enough
            repeat ($urandom_range(0, 8)) seg_bytes.push_back(8'($urandom));
            return;
        end

        a0 = rand64() | 64'h1;
        a1 = rand64() | 64'h2;
        for (int i = 0; i < n; i++)
        begin
            rid[i] = rand64() | 64'h100;
            if (i == 0 && $urandom_range(0, 7) == 0)
                rid[i] = '1;
            aid[i] = kind ? ($urandom_range(0, 1) ? a1 : a0) : rid[i];
            ord[i] = kind ? 32'(i) : 32'd0;
            flg[i] = 0;
        end
        r = $urandom_range(0, n - 1);
        case (c)
            C_RECZERO:
                if ($urandom_range(0, 1)) rid[r] = 0;
                else aid[r] = 0;
            C_FLAGS: flg[r] = 32'(1) << $urandom_range(0, 31);
            C_VISMISMATCH:
                if ($urandom_range(0, 1)) aid[r] = rid[r] ^ 64'h4000;
                else ord[r] = $urandom_range(1, 255);
            C_DUP:
                if (n >= 2)
                begin
                    r = $urandom_range(1, n - 1);
                    if (kind && $urandom_range(0, 1))
                    begin
                        aid[r] = aid[0];
                        ord[r] = ord[0];
                    end
                    else
                    begin
                        rid[r] = rid[0];
                        if (!kind) aid[r] = aid[0];
                    end
                end
            default: ;
        endcase
        for (int i = 0; i < n; i++)
        begin
            push_le(rid[i], 8);
            push_le(aid[i], 8);
            push_le(64'(ord[i]), 4);
            push_le(64'(flg[i]), 4);
        end
        r = seg_bytes.size() + $urandom_range(0, int'(off - tab_end) - 1);
        for (logic [63:0] k = tab_end; k < off; k++)
            seg_bytes.push_back(8'h00);
        if (c == C_PADDING)
            seg_bytes[r] = 8'($urandom_range(1, 255));
        for (logic [63:0] k = 0; k < plen; k++)
            seg_bytes.push_back(8'($urandom));
        if (c == C_FILELEN)
        begin
            if ($urandom_range(0, 1)) seg_bytes.push_back(8'($urandom));
            else void'(seg_bytes.pop_back());
        end
    endtask

    task automatic push_byte(logic [7:0] b, logic last);
        int g;
        g = tx_idle ? $urandom_range(0, 15) : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{data_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_segment(int typed);
        typed_status_q.push_back(typed);
        files_sent++;
        for (int i = 0; i < seg_bytes.size(); i++)
            push_byte(seg_bytes[i], i == seg_bytes.size() - 1);
    endtask

    task automatic drain_and_idle();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic load_config(logic [15:0] ver, logic [31:0] dim, logic [10:0] rec,
                               logic [7:0] vis, logic [7:0] txt);
        logic [31:0] vals [5];
        logic [2:0]  idx [5];
        vals = '{32'(ver), dim, 32'(rec), 32'(vis), 32'(txt)};
        idx = '{REG_FORMAT_VERSION, REG_MAX_DIMENSION, REG_MAX_RECORDS, REG_VISUAL_CODE,
                REG_TEXT_CODE};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        cfg_ver = ver;
        cfg_dim = dim;
        cfg_rec = rec;
        cfg_vis = vis;
        cfg_txt = txt;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("vector_segment_validator: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && in_valid && in_ready)
            predict_byte(in_data);

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            verdicts_seen++;
            if (verdicts_due.size() == 0)
            begin
                $error("result with none pending: status %0d", out_data.status);
                fails++;
            end
            else
            begin
                e = verdicts_due.pop_front();
                if (out_data.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, out_data.status);
                    fails++;
                end
                if (out_data.channel_kind !== e.channel_kind)
                begin
                    $error("channel_kind expected %0d actual %0d", e.channel_kind,
                           out_data.channel_kind);
                    fails++;
                end
                if (out_data.vector_dimension !== e.vector_dimension)
                begin
                    $error("vector_dimension expected %0d actual %0d", e.vector_dimension,
                           out_data.vector_dimension);
                    fails++;
                end
                if (out_data.record_total !== e.record_total)
                begin
                    $error("record_total expected %0d actual %0d", e.record_total,
                           out_data.record_total);
                    fails++;
                end
                if (out_data.payload_start !== e.payload_start)
                begin
                    $error("payload_start expected %0d actual %0d", e.payload_start,
                           out_data.payload_start);
                    fails++;
                end
            end
        end
    end

    // receiver: random stall per item while rx_idle is set, one long hold on request
    initial
    begin
        int g;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_long)
            begin
                out_ready <= 1'b0;
                repeat (500) @(negedge clk);
                rx_long = 0;
            end
            else
            begin
                g = rx_idle ? $urandom_range(0, 15) : 0;
                if (g > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (g) @(negedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        plan_row_t plan [22];
        flaw_e     c;
        int        phase_bytes;
        int        phase_seen;
        int        k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_FORMAT_VERSION;
        cfg_data = '0;
        fails = 0;
        cycles = 0;
        bytes_sent = 0;
        files_sent = 0;
        verdicts_seen = 0;
        tx_idle = 1;
        rx_idle = 1;
        rx_long = 0;
        cfg_ver = 16'd1;
        cfg_dim = 32'd4096;
        cfg_rec = 11'd1024;
        cfg_vis = 8'd1;
        cfg_txt = 8'd2;
        start_segment();
        plan = '{
            '{C_NONE, 0, 1, 1, NO_TYPED},
            '{C_NONE, 1, 3, 16, NO_TYPED},
            '{C_NONE, 0, 8, 4, NO_TYPED},
            '{C_TRUNC, 0, 1, 1, int'(ST_TRUNCATED)},
            '{C_NOISE, 0, 1, 1, NO_TYPED},
            '{C_MAGIC, 0, 1, 1, int'(ST_MAGIC)},
            '{C_VERSION, 1, 1, 1, int'(ST_VERSION)},
            '{C_HDRLEN, 0, 1, 1, int'(ST_HEADER)},
            '{C_HDRLEN, 1, 1, 1, int'(ST_HEADER)},
            '{C_CHANNEL, 0, 1, 1, int'(ST_CHANNEL)},
            '{C_ENCODING, 1, 1, 1, int'(ST_ENCODING)},
            '{C_SHAPE_DIM, 0, 1, 1, int'(ST_SHAPE)},
            '{C_SHAPE_CNT, 1, 1, 1, int'(ST_SHAPE)},
            '{C_IDENT, 0, 1, 1, int'(ST_IDENTITY)},
            '{C_LAYOUT_TAB, 1, 2, 3, int'(ST_LAYOUT)},
            '{C_FILELEN, 0, 2, 5, int'(ST_LAYOUT)},
            '{C_PADDING, 1, 2, 2, int'(ST_PADDING)},
            '{C_RECZERO, 1, 3, 2, int'(ST_RECORD)},
            '{C_FLAGS, 0, 2, 1, int'(ST_RECORD)},
            '{C_VISMISMATCH, 0, 3, 1, int'(ST_RECORD)},
            '{C_DUP, 0, 3, 1, int'(ST_DUPLICATE)},
            '{C_DUP, 1, 4, 2, int'(ST_DUPLICATE)}
        };
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values hold for the first directed files
        foreach (plan[i])
        begin
            build_segment(plan[i].c, plan[i].kind, plan[i].n, plan[i].dim);
            send_segment(plan[i].typed);
        end
        drain_and_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: load_config(16'd1, 32'd4096, 11'd1024, 8'd1, 8'd2);
                1: load_config(16'd0, 32'd1, 11'd1, 8'd0, 8'd255);
                2: load_config(16'hFFFF, 32'hFFFF_FFFF, 11'h7FF, 8'd255, 8'd0);
                3: load_config(16'($urandom), 32'd16, 11'd3, 8'd7, 8'd7);
                default: load_config(16'($urandom), 32'($urandom_range(8, 4096)),
                                     11'($urandom_range(40, 1024)), 8'($urandom),
                                     8'($urandom));
            endcase
            tx_idle = (ph != 1);
            rx_idle = (ph != 3);
            phase_bytes = bytes_sent;
            phase_seen = verdicts_seen;
            k = 0;
            while (bytes_sent - phase_bytes < 290 || verdicts_seen - phase_seen < 10)
            begin
                if (ph == 2 && k == 1)
                    rx_long = 1;
                if ($urandom_range(0, 1))
                    c = C_NONE;
                else
                    c = flaw_e'($urandom_range(int'(C_TRUNC), int'(C_DUP)));
                // short files while the receiver holds off, so the input backs up
                if (rx_long)
                    c = C_TRUNC;
                build_segment(c, $urandom_range(0, 1),
                              ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                           : $urandom_range(1, 4),
                              $urandom_range(1, 16));
                // broken file: one byte flipped somewhere
                if ($urandom_range(0, 9) == 0)
                    seg_bytes[$urandom_range(0, seg_bytes.size() - 1)] ^=
                        8'(1 << $urandom_range(0, 7));
                send_segment(NO_TYPED);
                k++;
            end
            drain_and_idle();
        end

        in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (verdicts_due.size() != 0)
        begin
            $error("%0d results never arrived", verdicts_due.size());
            fails++;
        end
        $display("ran %0d segment files, %0d bytes, %0d results over six settings",
                 files_sent, bytes_sent, verdicts_seen);
        $display("covered every status code, clamped record limit and shared channel codes");
        if (fails == 0)
            $display("vector_segment_validator: match");
        else
            $display("vector_segment_validator: mismatch");
        $finish;
    end

endmodule
